>>> hw/rtl/kcl_pkg.sv
// kcl_pkg: shared types and constants of the keypad combination lock
// no dependencies; used by every file of the block
package kcl_pkg;

  localparam int unsigned KeyW        = 8;
  localparam int unsigned CodeKeys    = 6;
  localparam int unsigned CodeW       = KeyW * CodeKeys;
  localparam int unsigned LenW        = 3;
  localparam int unsigned CfgIdxW     = 1;
  localparam int unsigned MaxKeysDef  = 6;

  // reset code "#12345", first key in the low byte
  localparam logic [CodeW-1:0] CodeKeysRst   = 48'h3534_3332_3123;
  localparam logic [LenW-1:0]  CodeLengthRst = 3'd6;

  localparam logic [CfgIdxW-1:0] CfgCodeKeys   = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgCodeLength = 1'b1;

  typedef struct packed {
    logic [KeyW-1:0] key;
    logic            relock;
  } in_t;

  typedef struct packed {
    logic            unlocked;
    logic [LenW-1:0] progress;
  } out_t;

endpackage

>>> hw/rtl/kcl_fsm.sv
// kcl_fsm: key matching machine, lock machine and the result register
// depends on kcl_pkg
module kcl_fsm import kcl_pkg::*; #(
  parameter int unsigned MaxKeys = MaxKeysDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  in_t              item_i,
  input  logic [CodeW-1:0] code_keys_i,
  input  logic [LenW-1:0]  code_length_i,
  output out_t             result_o
);

  typedef enum logic [1:0] {
    KpStart,
    KpInput,
    KpHeld,
    KpStop
  } key_phase_e;

  typedef enum logic [1:0] {
    LkStart,
    LkLocked,
    LkOpen
  } lock_phase_e;

  localparam int unsigned ExtW = KeyW * 8;
  localparam int unsigned SelW = $clog2(ExtW);

  key_phase_e      key_phase_q, key_phase_d;
  lock_phase_e     lock_phase_q, lock_phase_d;
  logic [LenW-1:0] match_idx_q, match_idx_d;
  logic            open_req_q, open_req_d;
  out_t            result_q;

  logic [ExtW-1:0] code_ext;
  logic            cur_match, prev_match;
  logic [LenW-1:0] prev_idx;
  logic [SelW-1:0] cur_sel, prev_sel;

  // positions past the stored code read as zero bytes
  assign code_ext = ExtW'(code_keys_i);
  assign prev_idx = match_idx_q - LenW'(1);
  assign cur_sel  = SelW'(match_idx_q) * SelW'(KeyW);
  assign prev_sel = SelW'(prev_idx) * SelW'(KeyW);

  assign cur_match  = ({1'b0, match_idx_q} < (LenW+1)'(MaxKeys)) &&
                      (code_ext[cur_sel +: KeyW] == item_i.key);
  assign prev_match = (match_idx_q != '0) &&
                      ({1'b0, prev_idx} < (LenW+1)'(MaxKeys)) &&
                      (code_ext[prev_sel +: KeyW] == item_i.key);

  always_comb begin
    key_phase_d  = key_phase_q;
    lock_phase_d = lock_phase_q;
    match_idx_d  = match_idx_q;
    open_req_d   = open_req_q;

    case (key_phase_q)
      KpStart: key_phase_d = KpInput;
      KpInput: begin
        if (item_i.key != '0) key_phase_d = KpHeld;
        if (open_req_q) key_phase_d = KpStop;
      end
      KpHeld: begin
        key_phase_d = prev_match ? KpHeld : KpInput;
        if (open_req_q) key_phase_d = KpStop;
      end
      default: begin
        if (!open_req_q) key_phase_d = KpInput;
      end
    endcase

    if (key_phase_d == KpInput) begin
      if (cur_match) begin
        match_idx_d = match_idx_q + LenW'(1);
      end else if (item_i.key != '0) begin
        match_idx_d = '0;
      end
      if (match_idx_d == code_length_i) begin
        open_req_d  = 1'b1;
        match_idx_d = '0;
      end
    end

    case (lock_phase_q)
      LkStart:  lock_phase_d = LkLocked;
      LkLocked: begin
        if (open_req_d) lock_phase_d = LkOpen;
      end
      LkOpen: begin
        if (item_i.relock) lock_phase_d = LkLocked;
      end
      default:  lock_phase_d = LkStart;
    endcase
    if (lock_phase_d == LkLocked) open_req_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_phase_q  <= KpStart;
      lock_phase_q <= LkStart;
      match_idx_q  <= '0;
      open_req_q   <= 1'b0;
      result_q     <= '0;
    end else if (step_i) begin
      key_phase_q       <= key_phase_d;
      lock_phase_q      <= lock_phase_d;
      match_idx_q       <= match_idx_d;
      open_req_q        <= open_req_d;
      result_q.unlocked <= (lock_phase_d == LkOpen);
      result_q.progress <= match_idx_d;
    end
  end

  assign result_o = result_q;

endmodule

>>> hw/rtl/keypad_combination_lock.sv
// keypad_combination_lock: top level with configuration registers and handshake
// depends on kcl_pkg and kcl_fsm
//
// Usage:
//   in channel  (in_valid_i / in_ready_o / in_data_i): one keypad sample per item,
//     key code (0 = no key) and the relock button.
//   out channel (out_valid_o / out_ready_i / out_data_o): one result per sample,
//     lock output and the number of code keys matched so far.
//   config port (cfg_we_i / cfg_idx_i / cfg_data_i): index 0 writes the six key
//     codes (first key in the low byte), index 1 the code length; write only
//     while no item is in flight.
// The result is registered: a sample accepted at one edge shows its result at the
// output from the next cycle on. Throughput is one item per cycle unless the
// output stalls; the key and lock machines update in a single pass on acceptance.
// The result register is the only stage: a new sample is taken while the held
// result is being taken in the same cycle. If the receiver stalls, the result
// holds and in_ready_o drops until it is taken.
// Reset puts both machines in their start phase, clears the match index and
// the open request, and loads the code "#12345" with length 6.
module keypad_combination_lock import kcl_pkg::*; #(
  parameter int unsigned MaxKeys = MaxKeysDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CodeW-1:0]   cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  in_t                in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output out_t               out_data_o
);

  logic [CodeW-1:0] code_keys_q;
  logic [LenW-1:0]  code_length_q;
  logic             out_valid_q;
  logic             accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_keys_q   <= CodeKeysRst;
      code_length_q <= CodeLengthRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgCodeKeys:   code_keys_q   <= cfg_data_i;
        CfgCodeLength: code_length_q <= cfg_data_i[LenW-1:0];
        default: ;
      endcase
    end
  end

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  kcl_fsm #(
    .MaxKeys(MaxKeys)
  ) u_fsm (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (accept),
    .item_i       (in_data_i),
    .code_keys_i  (code_keys_q),
    .code_length_i(code_length_q),
    .result_o     (out_data_o)
  );

  assign out_valid_o = out_valid_q;

endmodule

>>> hw/rtl/kcl_checker.sv
// kcl_checker: port level checks of the keypad combination lock, bound to the top
// depends on kcl_pkg
module kcl_checker import kcl_pkg::*; #(
  parameter int unsigned MaxKeys = MaxKeysDef
) (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input out_t out_data_o
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // input stalls only behind a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without output back-pressure");

  // every accepted item gives a result in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("accepted item gave no result");

  // progress never passes the number of code positions
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (MaxKeys >= 7) || (int'(out_data_o.progress) <= int'(MaxKeys)))
    else $error("progress beyond code positions");

endmodule

bind keypad_combination_lock kcl_checker #(
  .MaxKeys(MaxKeys)
) u_kcl_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_data_o (out_data_o)
);

>>> dv/tb.sv
// tb: self-checking testbench of keypad_combination_lock, a directed table then random
// keypad sessions under several code settings and idle patterns; needs kcl_pkg and the rtl
module tb;
  import kcl_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PhaseItems = 128;
  localparam int unsigned NumPhases  = 8;
  localparam int unsigned HoldOff    = 64;

  typedef enum logic [1:0] {KEY_START, KEY_INPUT, KEY_HELD, KEY_STOP} key_phase_e;
  typedef enum logic [1:0] {LOCK_START, LOCK_CLOSED, LOCK_OPEN, LOCK_SPARE} lock_phase_e;

  typedef struct {
    logic [KeyW-1:0] key;
    logic            relock;
    bit              typed;
    out_t            want;
  } row_t;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i   = '0;
  logic [CodeW-1:0]   cfg_data_i  = '0;
  logic               in_valid_i  = 1'b0;
  logic               in_ready_o;
  in_t                in_data_i   = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  out_t               out_data_o;

  // predictor state and register mirror
  logic [CodeW-1:0] code_keys_q;
  logic [LenW-1:0]  code_len_q;
  key_phase_e       key_ph;
  lock_phase_e      lock_ph;
  logic [LenW-1:0]  match_idx;
  logic             open_req;

  out_t        lock_outs_q[$];
  in_t         keypad_q[$];
  int unsigned mismatches   = 0;
  int unsigned items_sent   = 0;
  int unsigned results_seen = 0;
  int unsigned opens        = 0;
  bit          was_open     = 1'b0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  bit          hold_off_req  = 1'b0;

  // default code "#12345": enter it, open, relock, then a wrong key
  row_t directed [25] = '{
    '{8'h00, 1'b0, 1'b1, '{1'b0, 3'd0}},
    '{"#",   1'b0, 1'b0, '0}, '{"#", 1'b0, 1'b0, '0}, '{"#", 1'b0, 1'b0, '0},
    '{"#",   1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0},
    '{"1",   1'b0, 1'b0, '0}, '{"1", 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0},
    '{"2",   1'b0, 1'b0, '0}, '{"2", 1'b0, 1'b0, '0},
    '{"3",   1'b0, 1'b0, '0}, '{"3", 1'b0, 1'b0, '0},
    '{"4",   1'b0, 1'b0, '0}, '{"4", 1'b0, 1'b0, '0},
    '{"5",   1'b0, 1'b0, '0},
    '{"5",   1'b0, 1'b1, '{1'b1, 3'd0}},
    '{8'h00, 1'b0, 1'b1, '{1'b1, 3'd0}},
    '{8'h00, 1'b1, 1'b1, '{1'b0, 3'd0}},
    '{8'h00, 1'b0, 1'b0, '0},
    '{"#",   1'b0, 1'b0, '0}, '{"#", 1'b0, 1'b0, '0},
    '{"9",   1'b0, 1'b0, '0}, '{"9", 1'b0, 1'b0, '0},
    '{8'hFF, 1'b1, 1'b0, '0}
  };

  logic [CodeW-1:0] plan_code [NumPhases] = '{
    48'h0, 48'hFFFF_FFFF_FFFF, 48'h0, 48'h0, 48'h0, CodeKeysRst, 48'h0, 48'h0
  };
  logic [LenW-1:0] plan_len [NumPhases] = '{
    3'd0, 3'd7, 3'd1, 3'd3, 3'd6, 3'd6, 3'd5, 3'd2
  };

  keypad_combination_lock u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // positions past the code never match
  function automatic logic code_hit(logic [LenW-1:0] pos, logic [KeyW-1:0] k);
    if (pos >= MaxKeysDef) begin
      return 1'b0;
    end
    return code_keys_q[KeyW*pos +: KeyW] == k;
  endfunction

  function automatic out_t lock_step(in_t it);
    out_t res;
    case (key_ph)
      KEY_START: key_ph = KEY_INPUT;
      KEY_INPUT: begin
        if (it.key != '0) key_ph = KEY_HELD;
        if (open_req) key_ph = KEY_STOP;
      end
      KEY_HELD: begin
        if (match_idx != '0 && code_hit(match_idx - 3'd1, it.key)) key_ph = KEY_HELD;
        else key_ph = KEY_INPUT;
        if (open_req) key_ph = KEY_STOP;
      end
      default: begin
        if (!open_req) key_ph = KEY_INPUT;
      end
    endcase
    if (key_ph == KEY_INPUT) begin
      if (code_hit(match_idx, it.key)) match_idx = match_idx + 3'd1;
      else if (it.key != '0) match_idx = '0;
      if (match_idx == code_len_q) begin
        open_req  = 1'b1;
        match_idx = '0;
      end
    end
    case (lock_ph)
      LOCK_START:  lock_ph = LOCK_CLOSED;
      LOCK_CLOSED: begin
        if (open_req) lock_ph = LOCK_OPEN;
      end
      LOCK_OPEN: begin
        if (it.relock) lock_ph = LOCK_CLOSED;
      end
      default:     lock_ph = LOCK_START;
    endcase
    if (lock_ph == LOCK_CLOSED) open_req = 1'b0;
    res.unlocked = (lock_ph == LOCK_OPEN);
    res.progress = match_idx;
    return res;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("%0t ns: %s mismatch, got %0d expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  // after random idle cycles, holds the item until taken, then records its expected result
  task automatic offer(in_t it, bit typed, out_t typed_want);
    out_t res;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    res = lock_step(it);
    if (res.unlocked && !was_open) opens++;
    was_open = res.unlocked;
    lock_outs_q.push_back(typed ? typed_want : res);
    items_sent++;
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CodeW-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    if (idx == CfgCodeKeys) code_keys_q = val;
    else code_len_q = val[LenW-1:0];
  endtask

  task automatic drain();
    while (lock_outs_q.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    out_t want;
    if (out_valid_o && out_ready_i) begin
      results_seen++;
      if (lock_outs_q.size() == 0) begin
        report_mismatch("unexpected result", out_data_o, 0);
      end else begin
        want = lock_outs_q.pop_front();
        if (out_data_o.unlocked !== want.unlocked)
          report_mismatch("unlocked", out_data_o.unlocked, want.unlocked);
        if (out_data_o.progress !== want.progress)
          report_mismatch("progress", out_data_o.progress, want.progress);
      end
    end
  end

  // receiver: random stalls plus one long hold-off to back up the input
  initial begin : rx_side
    int unsigned hold_left;
    hold_left = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        hold_left    = HoldOff;
        hold_off_req = 1'b0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  initial begin : stim
    in_t              it;
    logic [CodeW-1:0] code;
    int unsigned      n_keys;
    int unsigned      miss_at;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    code_keys_q = CodeKeysRst;
    code_len_q  = CodeLengthRst;
    key_ph      = KEY_START;
    lock_ph     = LOCK_START;
    match_idx   = '0;
    open_req    = 1'b0;
    @(posedge clk_i);

    foreach (directed[i]) begin
      it.key    = directed[i].key;
      it.relock = directed[i].relock;
      offer(it, directed[i].typed, directed[i].want);
    end
    in_valid_i <= 1'b0;

    for (int ph = 0; ph < NumPhases; ph++) begin
      drain();
      code = plan_code[ph];
      if (code == '0 && ph != 0) begin
        for (int b = 0; b < CodeKeys; b++) code[KeyW*b +: KeyW] = 8'($urandom_range(1, 255));
      end
      // a zero byte in the middle advances without a key
      if (ph == 3) code[15:8] = '0;
      write_reg(CfgCodeKeys, code);
      write_reg(CfgCodeLength, {45'($urandom()), plan_len[ph]});
      cfg_we_i <= 1'b0;
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 47; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 47; end
        default: begin send_idle_pct = 37; stall_pct = 37; end
      endcase
      if (ph == 4) hold_off_req = 1'b1;

      keypad_q.delete();
      n_keys = (code_len_q == 0) ? 1 : ((code_len_q > CodeKeys) ? CodeKeys : code_len_q);
      while (keypad_q.size() < PhaseItems) begin
        case ($urandom_range(9))
          0, 1, 2, 3, 4, 5: begin
            // code entry, now and then with one wrong key
            miss_at = ($urandom_range(3) == 0) ? $urandom_range(n_keys - 1) : n_keys;
            for (int i = 0; i < n_keys; i++) begin
              it.key    = (i == miss_at) ? 8'($urandom_range(255)) : code_keys_q[KeyW*i +: KeyW];
              it.relock = ($urandom_range(31) == 0);
              repeat ($urandom_range(1, 3)) keypad_q.push_back(it);
              it.key    = '0;
              it.relock = 1'b0;
              repeat ($urandom_range(0, 2)) keypad_q.push_back(it);
            end
          end
          6, 7: begin
            repeat ($urandom_range(1, 6)) begin
              case ($urandom_range(2))
                0: it.key = '0;
                1: it.key = code_keys_q[KeyW*$urandom_range(CodeKeys - 1) +: KeyW];
                default: it.key = 8'($urandom_range(255));
              endcase
              it.relock = ($urandom_range(15) == 0);
              keypad_q.push_back(it);
            end
          end
          default: begin
            it.key    = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : '0;
            it.relock = 1'b1;
            repeat ($urandom_range(1, 2)) keypad_q.push_back(it);
          end
        endcase
      end

      foreach (keypad_q[i]) offer(keypad_q[i], 1'b0, '0);
      in_valid_i <= 1'b0;
    end
    drain();

    $display("covered %0d keypad items over %0d code settings and four idle patterns",
             items_sent, NumPhases + 1);
    $display("checked %0d results, lock opened %0d times, %0d mismatches",
             results_seen, opens, mismatches);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin : watchdog
    #1_000_000;
    $display("timeout waiting for results");
    $display("*** FAILED ***");
    $finish;
  end

endmodule
